@@ hdl/brb_pkg.sv @@
// Shared types, codes and field widths for the banked reorder buffer.
// No dependencies; every other file in the block imports this package.
package brb_pkg;

    localparam int unsigned NUM_BANKS_DEF  = 7;
    localparam int unsigned BANK_DEPTH_DEF = 112;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned TBANK_W  = 3;
    localparam int unsigned TSLOT_W  = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned GBANK_W  = 3;
    localparam int unsigned GSLOT_W  = 7;
    localparam int unsigned ACTIVE_W = 10;
    localparam int unsigned QOCC_W   = 7;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned ENTRY_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_RETIRE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

    localparam logic [ENTRY_W-1:0] ENTRY_FREE    = 2'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_ALLOC   = 2'd1;
    localparam logic [ENTRY_W-1:0] ENTRY_RETIRED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_SCAN,
        ST_ALLOC_WRITE,
        ST_RET_LOOKUP,
        ST_RET_CHECK,
        ST_RET_HEAD_RD,
        ST_RET_HEAD_CHK,
        ST_QUERY,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [TBANK_W-1:0] bank;
        logic [TSLOT_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GBANK_W-1:0]  granted_bank;
        logic [GSLOT_W-1:0]  granted_slot;
        logic [ACTIVE_W-1:0] active_entries;
        logic [QOCC_W-1:0]   queried_occupancy;
        logic [QOCC_W-1:0]   queried_peak;
        logic [COUNT_W-1:0]  total_allocations;
        logic [COUNT_W-1:0]  total_retirements;
        logic [COUNT_W-1:0]  total_stalls;
        logic [COUNT_W-1:0]  cycle_count;
    } result_t;

endpackage

@@ hdl/banked_reorder_buffer.sv @@
// Allocate scans the banks from the round-robin pointer until one has room; retire marks
// the entry retired, then frees retired entries from the bank head until a live one or
// an empty bank; a bad bank or slot or an unallocated entry ends the word early.
// One word at a time; s_ready returns the cycle after the result leaves the sequencer.
// aresetn is synchronous; entry status needs no clearing pass, an entry counts as
// free whenever it lies outside its bank's head/occupancy window.
module banked_reorder_buffer #(
    parameter int unsigned NUM_BANKS  = brb_pkg::NUM_BANKS_DEF,
    parameter int unsigned BANK_DEPTH = brb_pkg::BANK_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brb_pkg::FUNC_W-1:0]   s_func,
    input  logic [brb_pkg::TBANK_W-1:0]  s_target_bank,
    input  logic [brb_pkg::TSLOT_W-1:0]  s_target_slot,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brb_pkg::STATUS_W-1:0] m_status,
    output logic [brb_pkg::GBANK_W-1:0]  m_granted_bank,
    output logic [brb_pkg::GSLOT_W-1:0]  m_granted_slot,
    output logic [brb_pkg::ACTIVE_W-1:0] m_active_entries,
    output logic [brb_pkg::QOCC_W-1:0]   m_queried_occupancy,
    output logic [brb_pkg::QOCC_W-1:0]   m_queried_peak,
    output logic [brb_pkg::COUNT_W-1:0]  m_total_allocations,
    output logic [brb_pkg::COUNT_W-1:0]  m_total_retirements,
    output logic [brb_pkg::COUNT_W-1:0]  m_total_stalls,
    output logic [brb_pkg::COUNT_W-1:0]  m_cycle_count
);
    import brb_pkg::*;

    localparam int unsigned WORDS  = NUM_BANKS * BANK_DEPTH;
    localparam int unsigned ADDR_W = $clog2(WORDS);

    cmd_t    cmd;
    result_t result;
    result_t out_reg;
    logic    seq_idle, seq_done, take;
    logic    m_valid_reg, m_valid_next;

    logic               ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

    assign cmd.func = func_t'(s_func);
    assign cmd.bank = s_target_bank;
    assign cmd.slot = s_target_slot;

    assign s_ready = seq_idle;
    assign take    = seq_done && (!m_valid_reg || m_ready);

    brb_seq #(
        .NUM_BANKS  (NUM_BANKS),
        .BANK_DEPTH (BANK_DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && seq_idle),
        .cmd         (cmd),
        .idle        (seq_idle),
        .done        (seq_done),
        .take        (take),
        .result      (result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    brb_ram #(
        .WORDS (WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= result;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = out_reg.status;
    assign m_granted_bank      = out_reg.granted_bank;
    assign m_granted_slot      = out_reg.granted_slot;
    assign m_active_entries    = out_reg.active_entries;
    assign m_queried_occupancy = out_reg.queried_occupancy;
    assign m_queried_peak      = out_reg.queried_peak;
    assign m_total_allocations = out_reg.total_allocations;
    assign m_total_retirements = out_reg.total_retirements;
    assign m_total_stalls      = out_reg.total_stalls;
    assign m_cycle_count       = out_reg.cycle_count;

endmodule

@@ hdl/brb_ram.sv @@
// Entry status store: one write port, one registered read port.
// Depends on brb_pkg for the entry code width.
module brb_ram #(
    parameter int unsigned  WORDS  = brb_pkg::NUM_BANKS_DEF * brb_pkg::BANK_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(WORDS)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [brb_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [brb_pkg::ENTRY_W-1:0] rd_data
);
    import brb_pkg::*;

    logic [ENTRY_W-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/brb_seq.sv @@
// Sequencer, per-bank pointers, counters and the shared subtract/compare unit.
// Depends on brb_pkg; drives the entry status store in brb_ram.
module brb_seq #(
    parameter int unsigned  NUM_BANKS  = brb_pkg::NUM_BANKS_DEF,
    parameter int unsigned  BANK_DEPTH = brb_pkg::BANK_DEPTH_DEF,
    localparam int unsigned ADDR_W     = $clog2(NUM_BANKS * BANK_DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  brb_pkg::cmd_t               cmd,
    output logic                        idle,
    output logic                        done,
    input  logic                        take,
    output brb_pkg::result_t            result,
    output logic                        ram_wr_en,
    output logic [ADDR_W-1:0]           ram_wr_addr,
    output logic [brb_pkg::ENTRY_W-1:0] ram_wr_data,
    output logic                        ram_rd_en,
    output logic [ADDR_W-1:0]           ram_rd_addr,
    input  logic [brb_pkg::ENTRY_W-1:0] ram_rd_data
);
    import brb_pkg::*;

    localparam int unsigned BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int unsigned SLOT_W = $clog2(BANK_DEPTH);
    localparam int unsigned OCC_W  = $clog2(BANK_DEPTH + 1);
    localparam int unsigned TOT_W  = $clog2(NUM_BANKS * BANK_DEPTH + 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [BANK_W-1:0] bank_reg, bank_next;
    logic [BANK_W-1:0] scan_reg, scan_next;
    logic [BANK_W-1:0] nbank_reg, nbank_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] offset_reg, offset_next;

    logic [SLOT_W-1:0] head_reg [NUM_BANKS];
    logic [SLOT_W-1:0] head_next [NUM_BANKS];
    logic [SLOT_W-1:0] tail_reg [NUM_BANKS];
    logic [SLOT_W-1:0] tail_next [NUM_BANKS];
    logic [OCC_W-1:0]  occ_reg [NUM_BANKS];
    logic [OCC_W-1:0]  occ_next [NUM_BANKS];
    logic [OCC_W-1:0]  peak_reg [NUM_BANKS];
    logic [OCC_W-1:0]  peak_next [NUM_BANKS];

    logic [COUNT_W-1:0] alloc_cnt_reg, alloc_cnt_next;
    logic [COUNT_W-1:0] retire_cnt_reg, retire_cnt_next;
    logic [COUNT_W-1:0] stall_cnt_reg, stall_cnt_next;
    logic [COUNT_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [TOT_W-1:0]   total_reg, total_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GBANK_W-1:0]  gbank_reg, gbank_next;
    logic [GSLOT_W-1:0]  gslot_reg, gslot_next;
    logic [QOCC_W-1:0]   qocc_reg, qocc_next;
    logic [QOCC_W-1:0]   qpeak_reg, qpeak_next;

    logic [OCC_W-1:0]  op_a, op_b;
    logic [OCC_W:0]    diff;
    logic              lt;
    logic [SLOT_W-1:0] cur_head, cur_tail, addr_slot;
    logic [OCC_W-1:0]  cur_occ, cur_peak;
    logic [ADDR_W-1:0] addr;
    logic              bank_ok, slot_ok, scan_last;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(BANK_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [BANK_W-1:0] wrap_bank(input logic [BANK_W-1:0] b);
        return (b == BANK_W'(NUM_BANKS - 1)) ? '0 : b + 1'b1;
    endfunction

    assign cur_head  = head_reg[bank_reg];
    assign cur_tail  = tail_reg[bank_reg];
    assign cur_occ   = occ_reg[bank_reg];
    assign cur_peak  = peak_reg[bank_reg];
    assign bank_ok   = 32'(cmd_reg.bank) < NUM_BANKS;
    assign slot_ok   = 32'(cmd_reg.slot) < BANK_DEPTH;
    assign scan_last = scan_reg == BANK_W'(NUM_BANKS - 1);

    // shared subtract/compare unit
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_ALLOC_SCAN: begin
                op_a = cur_occ;
                op_b = OCC_W'(BANK_DEPTH);
            end
            ST_RET_LOOKUP: begin
                op_a = OCC_W'(slot_reg);
                op_b = OCC_W'(cur_head);
            end
            ST_RET_CHECK: begin
                op_a = OCC_W'(offset_reg);
                op_b = cur_occ;
            end
            default: begin
            end
        endcase
    end

    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign lt   = diff[OCC_W];

    always_comb begin
        unique case (state_reg)
            ST_RET_HEAD_RD: addr_slot = cur_head;
            ST_ALLOC_WRITE: addr_slot = cur_tail;
            default:        addr_slot = slot_reg;
        endcase
    end

    assign addr        = ADDR_W'(bank_reg) * ADDR_W'(BANK_DEPTH) + ADDR_W'(addr_slot);
    assign ram_wr_addr = addr;
    assign ram_rd_addr = addr;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (cmd_reg.func)
                    FUNC_ALLOC:  state_next = ST_ALLOC_SCAN;
                    FUNC_RETIRE: state_next = (bank_ok && slot_ok) ? ST_RET_LOOKUP : ST_DONE;
                    FUNC_TICK:   state_next = ST_DONE;
                    FUNC_QUERY:  state_next = bank_ok ? ST_QUERY : ST_DONE;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_ALLOC_SCAN: begin
                if (lt) begin
                    state_next = ST_ALLOC_WRITE;
                end else if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC_WRITE: state_next = ST_DONE;
            ST_RET_LOOKUP:  state_next = ST_RET_CHECK;
            ST_RET_CHECK: begin
                state_next = (lt && ram_rd_data == ENTRY_ALLOC) ? ST_RET_HEAD_RD : ST_DONE;
            end
            ST_RET_HEAD_RD: begin
                state_next = (cur_occ == '0) ? ST_DONE : ST_RET_HEAD_CHK;
            end
            ST_RET_HEAD_CHK: begin
                state_next = (ram_rd_data == ENTRY_RETIRED) ? ST_RET_HEAD_RD : ST_DONE;
            end
            ST_QUERY: state_next = ST_DONE;
            ST_DONE: begin
                if (take) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        bank_next       = bank_reg;
        scan_next       = scan_reg;
        nbank_next      = nbank_reg;
        slot_next       = slot_reg;
        offset_next     = offset_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        peak_next       = peak_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        retire_cnt_next = retire_cnt_reg;
        stall_cnt_next  = stall_cnt_reg;
        tick_cnt_next   = tick_cnt_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        gbank_next      = gbank_reg;
        gslot_next      = gslot_reg;
        qocc_next       = qocc_reg;
        qpeak_next      = qpeak_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = ENTRY_FREE;
        ram_rd_en       = 1'b0;
        unique case (state_reg)
            ST_DECODE: begin
                status_next = STATUS_OK;
                gbank_next  = '0;
                gslot_next  = '0;
                qocc_next   = '0;
                qpeak_next  = '0;
                scan_next   = '0;
                slot_next   = SLOT_W'(cmd_reg.slot);
                bank_next   = (cmd_reg.func == FUNC_ALLOC) ? nbank_reg : BANK_W'(cmd_reg.bank);
                unique case (cmd_reg.func)
                    FUNC_RETIRE: begin
                        if (!(bank_ok && slot_ok)) status_next = STATUS_INVALID;
                    end
                    FUNC_QUERY: begin
                        if (!bank_ok) status_next = STATUS_INVALID;
                    end
                    FUNC_TICK: tick_cnt_next = tick_cnt_reg + 1'b1;
                    default: begin
                    end
                endcase
            end
            ST_ALLOC_SCAN: begin
                if (!lt) begin
                    if (scan_last) begin
                        stall_cnt_next = stall_cnt_reg + 1'b1;
                        status_next    = STATUS_FULL;
                    end else begin
                        bank_next = wrap_bank(bank_reg);
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            ST_ALLOC_WRITE: begin
                ram_wr_en           = 1'b1;
                ram_wr_data         = ENTRY_ALLOC;
                tail_next[bank_reg] = wrap_slot(cur_tail);
                occ_next[bank_reg]  = cur_occ + 1'b1;
                if (cur_occ == cur_peak) peak_next[bank_reg] = cur_occ + 1'b1;
                alloc_cnt_next = alloc_cnt_reg + 1'b1;
                total_next     = total_reg + 1'b1;
                nbank_next     = wrap_bank(bank_reg);
                gbank_next     = GBANK_W'(bank_reg);
                gslot_next     = GSLOT_W'(cur_tail);
            end
            ST_RET_LOOKUP: begin
                ram_rd_en   = 1'b1;
                offset_next = lt ? SLOT_W'(diff[OCC_W-1:0] + OCC_W'(BANK_DEPTH))
                                 : SLOT_W'(diff[OCC_W-1:0]);
            end
            ST_RET_CHECK: begin
                if (lt && ram_rd_data == ENTRY_ALLOC) begin
                    ram_wr_en       = 1'b1;
                    ram_wr_data     = ENTRY_RETIRED;
                    retire_cnt_next = retire_cnt_reg + 1'b1;
                end else begin
                    status_next = STATUS_NOT_ALLOC;
                end
            end
            ST_RET_HEAD_RD: begin
                ram_rd_en = cur_occ != '0;
            end
            ST_RET_HEAD_CHK: begin
                if (ram_rd_data == ENTRY_RETIRED) begin
                    head_next[bank_reg] = wrap_slot(cur_head);
                    occ_next[bank_reg]  = cur_occ - 1'b1;
                    total_next          = total_reg - 1'b1;
                end
            end
            ST_QUERY: begin
                qocc_next  = QOCC_W'(cur_occ);
                qpeak_next = QOCC_W'(cur_peak);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            nbank_reg      <= '0;
            alloc_cnt_reg  <= '0;
            retire_cnt_reg <= '0;
            stall_cnt_reg  <= '0;
            tick_cnt_reg   <= '0;
            total_reg      <= '0;
            for (int i = 0; i < NUM_BANKS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            nbank_reg      <= nbank_next;
            alloc_cnt_reg  <= alloc_cnt_next;
            retire_cnt_reg <= retire_cnt_next;
            stall_cnt_reg  <= stall_cnt_next;
            tick_cnt_reg   <= tick_cnt_next;
            total_reg      <= total_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            peak_reg       <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            cmd_reg <= cmd;
        end
        bank_reg   <= bank_next;
        scan_reg   <= scan_next;
        slot_reg   <= slot_next;
        offset_reg <= offset_next;
        status_reg <= status_next;
        gbank_reg  <= gbank_next;
        gslot_reg  <= gslot_next;
        qocc_reg   <= qocc_next;
        qpeak_reg  <= qpeak_next;
    end

    assign idle = state_reg == ST_IDLE;
    assign done = state_reg == ST_DONE;

    assign result.status            = status_reg;
    assign result.granted_bank      = gbank_reg;
    assign result.granted_slot      = gslot_reg;
    assign result.active_entries    = ACTIVE_W'(total_reg);
    assign result.queried_occupancy = qocc_reg;
    assign result.queried_peak      = qpeak_reg;
    assign result.total_allocations = alloc_cnt_reg;
    assign result.total_retirements = retire_cnt_reg;
    assign result.total_stalls      = stall_cnt_reg;
    assign result.cycle_count       = tick_cnt_reg;

endmodule

@@ hdl/brb_checker.sv @@
// Port-level checks for banked_reorder_buffer, attached by the bind below.
// Depends on brb_pkg for field widths and status codes.
module brb_assertions #(
    parameter int unsigned NUM_BANKS  = brb_pkg::NUM_BANKS_DEF,
    parameter int unsigned BANK_DEPTH = brb_pkg::BANK_DEPTH_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [brb_pkg::FUNC_W-1:0]   s_func,
    input logic [brb_pkg::TBANK_W-1:0]  s_target_bank,
    input logic [brb_pkg::TSLOT_W-1:0]  s_target_slot,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [brb_pkg::STATUS_W-1:0] m_status,
    input logic [brb_pkg::GBANK_W-1:0]  m_granted_bank,
    input logic [brb_pkg::GSLOT_W-1:0]  m_granted_slot,
    input logic [brb_pkg::ACTIVE_W-1:0] m_active_entries,
    input logic [brb_pkg::QOCC_W-1:0]   m_queried_occupancy,
    input logic [brb_pkg::QOCC_W-1:0]   m_queried_peak,
    input logic [brb_pkg::COUNT_W-1:0]  m_total_allocations,
    input logic [brb_pkg::COUNT_W-1:0]  m_total_retirements,
    input logic [brb_pkg::COUNT_W-1:0]  m_total_stalls,
    input logic [brb_pkg::COUNT_W-1:0]  m_cycle_count
);
    import brb_pkg::*;

    localparam logic [ACTIVE_W-1:0] FULL_COUNT = ACTIVE_W'(NUM_BANKS * BANK_DEPTH);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_total_allocations))
        else $error("result word changed or dropped while stalled");

    // one word at a time: drop ready after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in progress");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FULL |-> m_active_entries == FULL_COUNT)
        else $error("full reported with free entries");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |->
            m_granted_bank == '0 && m_granted_slot == '0 &&
            m_queried_occupancy == '0 && m_queried_peak == '0)
        else $error("refused word carries grant or query data");

    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_queried_peak >= m_queried_occupancy)
        else $error("queried peak below queried occupancy");

endmodule

bind banked_reorder_buffer brb_assertions #(
    .NUM_BANKS  (NUM_BANKS),
    .BANK_DEPTH (BANK_DEPTH)
) u_brb_assertions (.*);

@@ dv/brb_checker.sv @@
// Scoreboard for the banked reorder buffer: predicts every result word from the
// accepted input words and compares each field. Depends on brb_pkg only.
module brb_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [brb_pkg::FUNC_W-1:0]   s_func,
    input  logic [brb_pkg::TBANK_W-1:0]  s_target_bank,
    input  logic [brb_pkg::TSLOT_W-1:0]  s_target_slot,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [brb_pkg::STATUS_W-1:0] m_status,
    input  logic [brb_pkg::GBANK_W-1:0]  m_granted_bank,
    input  logic [brb_pkg::GSLOT_W-1:0]  m_granted_slot,
    input  logic [brb_pkg::ACTIVE_W-1:0] m_active_entries,
    input  logic [brb_pkg::QOCC_W-1:0]   m_queried_occupancy,
    input  logic [brb_pkg::QOCC_W-1:0]   m_queried_peak,
    input  logic [brb_pkg::COUNT_W-1:0]  m_total_allocations,
    input  logic [brb_pkg::COUNT_W-1:0]  m_total_retirements,
    input  logic [brb_pkg::COUNT_W-1:0]  m_total_stalls,
    input  logic [brb_pkg::COUNT_W-1:0]  m_cycle_count,
    output int                           mismatches,
    output int                           outstanding
);
    import brb_pkg::*;

    localparam int NB = NUM_BANKS_DEF;
    localparam int BD = BANK_DEPTH_DEF;

    logic [ENTRY_W-1:0] slot_state [NB][BD];
    logic [TSLOT_W-1:0] head_slot [NB];
    logic [TSLOT_W-1:0] tail_slot [NB];
    logic [TSLOT_W-1:0] occupancy [NB];
    logic [TSLOT_W-1:0] peak_occ [NB];
    logic [GBANK_W-1:0] rr_bank;
    logic [COUNT_W-1:0] alloc_cnt;
    logic [COUNT_W-1:0] retire_cnt;
    logic [COUNT_W-1:0] stall_cnt;
    logic [COUNT_W-1:0] tick_cnt;

    result_t due_results[$];
    result_t want;

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    task automatic reorder_step(input func_t f, input logic [TBANK_W-1:0] bank,
                                input logic [TSLOT_W-1:0] slot);
        result_t r;
        int b;
        int i;
        bit found;
        int unsigned total;
        r = '0;
        case (f)
            FUNC_ALLOC: begin
                b = int'(rr_bank);
                found = 1'b0;
                for (i = 0; i < NB && !found; i++) begin
                    if (occupancy[b] < BD) begin
                        found = 1'b1;
                    end else begin
                        b = (b + 1) % NB;
                    end
                end
                if (!found) begin
                    stall_cnt++;
                    r.status = STATUS_FULL;
                end else begin
                    r.granted_bank = GBANK_W'(b);
                    r.granted_slot = tail_slot[b];
                    slot_state[b][tail_slot[b]] = ENTRY_ALLOC;
                    tail_slot[b] = (tail_slot[b] == BD - 1) ? '0 : tail_slot[b] + 1'b1;
                    occupancy[b] = occupancy[b] + 1'b1;
                    if (occupancy[b] > peak_occ[b]) begin
                        peak_occ[b] = occupancy[b];
                    end
                    rr_bank = GBANK_W'((b + 1) % NB);
                    alloc_cnt++;
                end
            end
            FUNC_RETIRE: begin
                if (bank >= NB || slot >= BD) begin
                    r.status = STATUS_INVALID;
                end else if (slot_state[bank][slot] != ENTRY_ALLOC) begin
                    r.status = STATUS_NOT_ALLOC;
                end else begin
                    slot_state[bank][slot] = ENTRY_RETIRED;
                    retire_cnt++;
                    while (occupancy[bank] > 0 &&
                           slot_state[bank][head_slot[bank]] == ENTRY_RETIRED) begin
                        slot_state[bank][head_slot[bank]] = ENTRY_FREE;
                        head_slot[bank] = (head_slot[bank] == BD - 1) ? '0
                                                                      : head_slot[bank] + 1'b1;
                        occupancy[bank] = occupancy[bank] - 1'b1;
                    end
                end
            end
            FUNC_TICK: begin
                tick_cnt++;
            end
            default: begin
                if (bank >= NB) begin
                    r.status = STATUS_INVALID;
                end else begin
                    r.queried_occupancy = occupancy[bank];
                    r.queried_peak = peak_occ[bank];
                end
            end
        endcase
        total = 0;
        for (i = 0; i < NB; i++) begin
            total += occupancy[i];
        end
        r.active_entries = ACTIVE_W'(total);
        r.total_allocations = alloc_cnt;
        r.total_retirements = retire_cnt;
        r.total_stalls = stall_cnt;
        r.cycle_count = tick_cnt;
        due_results.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [COUNT_W-1:0] exp_val,
                               input logic [COUNT_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        int bi;
        int si;
        if (!aresetn) begin
            for (bi = 0; bi < NB; bi++) begin
                for (si = 0; si < BD; si++) begin
                    slot_state[bi][si] = ENTRY_FREE;
                end
                head_slot[bi] = '0;
                tail_slot[bi] = '0;
                occupancy[bi] = '0;
                peak_occ[bi] = '0;
            end
            rr_bank = '0;
            alloc_cnt = '0;
            retire_cnt = '0;
            stall_cnt = '0;
            tick_cnt = '0;
            due_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                reorder_step(func_t'(s_func), s_target_bank, s_target_slot);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result word with none expected: status %0d, active %0d",
                             $time, m_status, m_active_entries);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("granted_bank", want.granted_bank, m_granted_bank);
                    check_field("granted_slot", want.granted_slot, m_granted_slot);
                    check_field("active_entries", want.active_entries, m_active_entries);
                    check_field("queried_occupancy", want.queried_occupancy,
                                m_queried_occupancy);
                    check_field("queried_peak", want.queried_peak, m_queried_peak);
                    check_field("total_allocations", want.total_allocations,
                                m_total_allocations);
                    check_field("total_retirements", want.total_retirements,
                                m_total_retirements);
                    check_field("total_stalls", want.total_stalls, m_total_stalls);
                    check_field("cycle_count", want.cycle_count, m_cycle_count);
                end
            end
        end
        outstanding <= due_results.size();
    end

endmodule

@@ dv/tb_banked_reorder_buffer.sv @@
// Top of the banked reorder buffer regression: clock, reset, input words and the
// result-side stall pattern, plus the verdict. Needs brb_pkg, the block and brb_checker.
module tb_banked_reorder_buffer;
    import brb_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func = '0;
    logic [TBANK_W-1:0]  s_target_bank = '0;
    logic [TSLOT_W-1:0]  s_target_slot = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [GBANK_W-1:0]  m_granted_bank;
    logic [GSLOT_W-1:0]  m_granted_slot;
    logic [ACTIVE_W-1:0] m_active_entries;
    logic [QOCC_W-1:0]   m_queried_occupancy;
    logic [QOCC_W-1:0]   m_queried_peak;
    logic [COUNT_W-1:0]  m_total_allocations;
    logic [COUNT_W-1:0]  m_total_retirements;
    logic [COUNT_W-1:0]  m_total_stalls;
    logic [COUNT_W-1:0]  m_cycle_count;
    int                  mismatches;
    int                  outstanding;

    bit                  calm = 1'b0;
    logic [COUNT_W-1:0]  seen_allocs = '0;
    logic [COUNT_W-1:0]  seen_stalls = '0;
    logic [TBANK_W+TSLOT_W-1:0] live_entries[$];

    banked_reorder_buffer u_top (.*);

    brb_checker u_checker (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 28);
    end

    // collect granted entries so that retires can name live ones
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_total_allocations != seen_allocs) begin
                live_entries.push_back({m_granted_bank, m_granted_slot});
                seen_allocs = m_total_allocations;
            end
            seen_stalls = m_total_stalls;
        end
    end

    task automatic send_word(input func_t f, input logic [TBANK_W-1:0] bank,
                             input logic [TSLOT_W-1:0] slot);
        s_valid <= 1'b1;
        s_func <= f;
        s_target_bank <= bank;
        s_target_slot <= slot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        while (!calm && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic retire_live();
        int pick;
        logic [TBANK_W+TSLOT_W-1:0] e;
        if (live_entries.size() == 0) begin
            send_word(FUNC_QUERY, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end else begin
            pick = $urandom_range(0, live_entries.size() - 1);
            e = live_entries[pick];
            live_entries.delete(pick);
            send_word(FUNC_RETIRE, e[TBANK_W+TSLOT_W-1:TSLOT_W], e[TSLOT_W-1:0]);
        end
    endtask

    task automatic mixed_word(input int alloc_pct, input int retire_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            send_word(FUNC_ALLOC, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end else if (roll < alloc_pct + retire_pct) begin
            retire_live();
        end else begin
            case ($urandom_range(0, 2))
                0: send_word(FUNC_RETIRE, 3'($urandom_range(0, 7)),
                             7'($urandom_range(0, 127)));
                1: send_word(FUNC_TICK, 3'($urandom_range(0, 7)),
                             7'($urandom_range(0, 127)));
                default: send_word(FUNC_QUERY, 3'($urandom_range(0, 7)),
                                   7'($urandom_range(0, 127)));
            endcase
        end
    endtask

    initial begin
        #20000000;
        $display("banked_reorder_buffer regression: fail");
        $finish;
    end

    initial begin
        int k;
        int n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(FUNC_QUERY, 3'd0, 7'd0);
        send_word(FUNC_QUERY, 3'd7, 7'd0);
        send_word(FUNC_TICK, 3'd0, 7'd0);
        send_word(FUNC_TICK, 3'd7, 7'd127);
        send_word(FUNC_RETIRE, 3'd7, 7'd0);
        send_word(FUNC_RETIRE, 3'd0, 7'd112);
        send_word(FUNC_RETIRE, 3'd6, 7'd127);
        send_word(FUNC_RETIRE, 3'd3, 7'd5);
        for (k = 0; k < 8; k++) begin
            send_word(FUNC_ALLOC, (k % 2) ? 3'd7 : 3'd0, (k % 2) ? 7'd127 : 7'd0);
        end
        send_word(FUNC_RETIRE, 3'd0, 7'd1);
        send_word(FUNC_RETIRE, 3'd0, 7'd1);
        send_word(FUNC_RETIRE, 3'd0, 7'd0);
        send_word(FUNC_RETIRE, 3'd0, 7'd0);
        send_word(FUNC_QUERY, 3'd0, 7'd127);
        send_word(FUNC_QUERY, 3'd6, 7'd64);
        send_word(FUNC_RETIRE, 3'd6, 7'd111);

        // drop the two entries already retired by hand from the live list
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        for (k = live_entries.size() - 1; k >= 0; k--) begin
            if (live_entries[k][TBANK_W+TSLOT_W-1:TSLOT_W] == 0 &&
                live_entries[k][TSLOT_W-1:0] < 2) begin
                live_entries.delete(k);
            end
        end

        repeat (100) mixed_word(40, 30);

        n = 0;
        calm = 1'b1;
        while (seen_stalls < 12) begin
            mixed_word(92, 0);
            n++;
            if (n == 300) begin
                calm = 1'b0;
            end
        end
        calm = 1'b0;

        repeat (180) mixed_word(15, 65);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("banked_reorder_buffer regression: pass");
        end else begin
            $display("banked_reorder_buffer regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_seq.sv
hdl/banked_reorder_buffer.sv
hdl/brb_checker.sv
dv/brb_checker.sv
dv/tb_banked_reorder_buffer.sv
